// File: src/stt_pkg.sv
`default_nettype none

package stt_pkg;

  // Table geometry and field widths
  localparam int CAPACITY          = 128;
  localparam int ADDR_BITS         = $clog2(CAPACITY);
  localparam int CNT_BITS          = $clog2(CAPACITY + 1);
  localparam int INDEX_BITS        = 16;
  localparam int VALUE_BITS        = 32;
  localparam int KEY_BITS          = 2 * INDEX_BITS;
  localparam int SHAPE_BITS        = INDEX_BITS + 1;
  localparam int ENTRY_COUNT_BITS  = 8;
  localparam int STATUS_BITS       = 2;
  localparam int CFG_IDX_BITS      = 1;

  typedef enum logic {
    CMD_STORE    = 1'b0,
    CMD_RETRIEVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } result_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_ROWS = 1'b0,
    CFG_NUM_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic         load;        // latch item, open search window
    logic         srch_rd;     // read entry at window midpoint
    logic         srch_upd;    // narrow window from midpoint compare
    logic         pos_rd;      // read entry at insertion point
    logic         shift_init;  // start shift pointer at entry count
    logic         shift_step;  // move one entry up
    logic         ins_wr;      // write new entry at insertion point
    logic         upd_wr;      // overwrite value at insertion point
    logic         resp;        // register result
    result_code_t resp_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic shift_done;
    logic is_retrieve;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/stt_ctrl.sv
`default_nettype none

module stt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire stt_pkg::dp_stat_t  stat,
  output stt_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_SWAIT  = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_SHIFT  = 9'b000100000,
    S_INSERT = 9'b001000000,
    S_RESP   = 9'b010000000,
    S_UPDATE = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  stt_pkg::result_code_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= stt_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    cmd             = '0;
    cmd.resp_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.in_range) begin
          status_nxt = stt_pkg::ST_RANGE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SWAIT;
        end else begin
          cmd.pos_rd = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_SWAIT: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SEARCH;
      end
      S_DECIDE: begin
        if (stat.is_retrieve) begin
          status_nxt = stat.hit ? stt_pkg::ST_OK : stt_pkg::ST_NOTFOUND;
          state_nxt  = S_RESP;
        end else if (stat.hit) begin
          status_nxt = stt_pkg::ST_OK;
          state_nxt  = S_UPDATE;
        end else if (stat.full) begin
          status_nxt = stt_pkg::ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          status_nxt     = stt_pkg::ST_OK;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_UPDATE: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_RESP;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        cmd.resp  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/stt_datapath.sv
`default_nettype none

module stt_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire stt_pkg::ctrl_cmd_t                  cmd,
  output stt_pkg::dp_stat_t                        stat,
  input  wire logic                                in_cmd,
  input  wire logic [stt_pkg::INDEX_BITS-1:0]      in_row_index,
  input  wire logic [stt_pkg::INDEX_BITS-1:0]      in_col_index,
  input  wire logic [stt_pkg::VALUE_BITS-1:0]      in_write_value,
  input  wire logic                                cfg_we,
  input  wire logic [stt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [stt_pkg::SHAPE_BITS-1:0]      cfg_data,
  output logic                                     out_valid,
  output logic [stt_pkg::STATUS_BITS-1:0]          out_status,
  output logic [stt_pkg::VALUE_BITS-1:0]           out_read_value,
  output logic [stt_pkg::ENTRY_COUNT_BITS-1:0]     out_entry_count
);

  // Entry storage
  stt_pkg::entry_t mem [stt_pkg::CAPACITY];

  logic [stt_pkg::SHAPE_BITS-1:0] num_rows_r, num_cols_r;

  stt_pkg::cmd_t                  cmd_r;
  logic [stt_pkg::INDEX_BITS-1:0] row_r, col_r;
  logic [stt_pkg::VALUE_BITS-1:0] val_r;
  logic [stt_pkg::KEY_BITS-1:0]   key;

  logic [stt_pkg::CNT_BITS-1:0]   count_r;
  logic [stt_pkg::CNT_BITS-1:0]   lo_r, hi_r;
  logic [stt_pkg::ADDR_BITS-1:0]  mid_r;
  logic [stt_pkg::CNT_BITS-1:0]   ptr_r;
  logic [stt_pkg::ADDR_BITS-1:0]  wr_addr_r;
  logic                           pend_r;
  stt_pkg::entry_t                rdata_r;

  logic [stt_pkg::CNT_BITS:0]     mid_sum;
  logic [stt_pkg::ADDR_BITS-1:0]  mid;
  logic [stt_pkg::CNT_BITS-1:0]   ptr_dec;
  logic                           ptr_gt_pos;
  logic                           rd_en, we;
  logic [stt_pkg::ADDR_BITS-1:0]  rd_addr, wr_addr;
  stt_pkg::entry_t                wdata;

  logic                                  out_valid_r;
  stt_pkg::result_code_t                 out_status_r;
  logic [stt_pkg::VALUE_BITS-1:0]        out_read_value_r;
  logic [stt_pkg::ENTRY_COUNT_BITS-1:0]  out_entry_count_r;

  assign key        = {row_r, col_r};
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[stt_pkg::ADDR_BITS:1];
  assign ptr_dec    = ptr_r - 1'b1;
  assign ptr_gt_pos = (ptr_r > lo_r);

  always_comb begin
    stat.in_range    = ({1'b0, row_r} < num_rows_r) && ({1'b0, col_r} < num_cols_r);
    stat.lo_lt_hi    = (lo_r < hi_r);
    stat.hit         = (lo_r < count_r) && (rdata_r.key == key);
    stat.full        = (count_r == stt_pkg::CNT_BITS'(stt_pkg::CAPACITY));
    stat.shift_done  = !ptr_gt_pos && !pend_r;
    stat.is_retrieve = (cmd_r == stt_pkg::CMD_RETRIEVE);
  end

  // Memory port selection
  always_comb begin
    rd_en   = cmd.srch_rd || cmd.pos_rd || (cmd.shift_step && ptr_gt_pos);
    rd_addr = lo_r[stt_pkg::ADDR_BITS-1:0];
    if (cmd.srch_rd) begin
      rd_addr = mid;
    end else if (cmd.shift_step) begin
      rd_addr = ptr_dec[stt_pkg::ADDR_BITS-1:0];
    end
    we      = cmd.ins_wr || cmd.upd_wr || (cmd.shift_step && pend_r);
    wr_addr = lo_r[stt_pkg::ADDR_BITS-1:0];
    wdata   = '{key: key, value: val_r};
    if (cmd.shift_step) begin
      wr_addr = wr_addr_r;
      wdata   = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Shape registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= '0;
      num_cols_r <= '0;
    end else if (cfg_we) begin
      case (stt_pkg::cfg_idx_t'(cfg_index))
        stt_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_data;
        stt_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item payload, probe midpoint and shift write address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= stt_pkg::cmd_t'(in_cmd);
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_write_value;
    end
    if (cmd.srch_rd) begin
      mid_r <= mid;
    end
    if (cmd.shift_step && ptr_gt_pos) begin
      wr_addr_r <= ptr_r[stt_pkg::ADDR_BITS-1:0];
    end
  end

  // Search window, shift pointer, count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        lo_r <= '0;
        hi_r <= count_r;
      end else if (cmd.srch_upd) begin
        if (rdata_r.key < key) begin
          lo_r <= {1'b0, mid_r} + 1'b1;
        end else begin
          hi_r <= {1'b0, mid_r};
        end
      end
      if (cmd.shift_init) begin
        ptr_r  <= count_r;
        pend_r <= 1'b0;
      end else if (cmd.shift_step) begin
        pend_r <= ptr_gt_pos;
        if (ptr_gt_pos) begin
          ptr_r <= ptr_dec;
        end
      end
      if (cmd.ins_wr) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status_r      <= cmd.resp_status;
      out_read_value_r  <= (cmd.resp_status == stt_pkg::ST_OK &&
                            cmd_r == stt_pkg::CMD_RETRIEVE) ? rdata_r.value : '0;
      out_entry_count_r <= stt_pkg::ENTRY_COUNT_BITS'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stt_pkg::CNT_BITS'(stt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !stat.full)
    else $error("insert into full table");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_upd |=> lo_r <= hi_r)
    else $error("search window inverted");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// File: src/sorted_triplet_table_unit.sv
`default_nettype none

// Sparse matrix triplet table: holds up to 128 (row, col, value) entries
// sorted by row, then column.
// Input channel: raise start with in_cmd (store or retrieve), in_row_index,
// in_col_index and in_write_value; the item is taken at an edge where start
// is high and busy is low. busy stays high until the result is on the ports.
// Result channel: out_valid pulses for exactly one cycle with out_status,
// out_read_value and out_entry_count. The receiver cannot stall; the result
// must be taken in that cycle.
// Configuration: cfg_we, cfg_index (0 rows, 1 columns) and cfg_data write
// the matrix shape; write only while busy is low.
// Steps from the accepting edge: range check; up to 8 search probes, each
// a read and a window narrowing; a read to test the hit; on a store hit an
// overwrite, on an insert each entry from the insertion point on moved up,
// then the new entry written; the result registered, then out_valid high.
// Out of range, a retrieve or a full table skip to the result. busy is low
// in the out_valid cycle, so the next item can go on the edge ending it. The
// entry memory has one read and one write port: one read per search probe.
// Reset empties the table and clears the shape to zero, so every item
// reports out of range until the shape is written.
module sorted_triplet_table_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_cmd,
  input  wire logic [stt_pkg::INDEX_BITS-1:0]      in_row_index,
  input  wire logic [stt_pkg::INDEX_BITS-1:0]      in_col_index,
  input  wire logic [stt_pkg::VALUE_BITS-1:0]      in_write_value,
  output logic                                     out_valid,
  output logic [stt_pkg::STATUS_BITS-1:0]          out_status,
  output logic [stt_pkg::VALUE_BITS-1:0]           out_read_value,
  output logic [stt_pkg::ENTRY_COUNT_BITS-1:0]     out_entry_count,
  input  wire logic                                cfg_we,
  input  wire logic [stt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [stt_pkg::SHAPE_BITS-1:0]      cfg_data
);

  // Command bundle from the sequencer, status bundle back from the datapath
  stt_pkg::ctrl_cmd_t ctrl_cmd;
  stt_pkg::dp_stat_t  dp_stat;

  // Sequencer: range check, search probes, shift loop, result strobe
  stt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctrl_cmd)
  );

  // Datapath: entry memory, shape registers, search window, result register
  stt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_write_value  (in_write_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

// File: tb/triplet_table_checker.sv
`default_nettype none

module triplet_table_checker
  import stt_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic                         in_cmd,
  input  wire logic [INDEX_BITS-1:0]        in_row_index,
  input  wire logic [INDEX_BITS-1:0]        in_col_index,
  input  wire logic [VALUE_BITS-1:0]        in_write_value,
  input  wire logic                         out_valid,
  input  wire logic [STATUS_BITS-1:0]       out_status,
  input  wire logic [VALUE_BITS-1:0]        out_read_value,
  input  wire logic [ENTRY_COUNT_BITS-1:0]  out_entry_count,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [SHAPE_BITS-1:0]        cfg_data,
  output int                                mismatch_count,
  output int                                outstanding
);

  typedef struct packed {
    result_code_t                  status;
    logic [VALUE_BITS-1:0]         value;
    logic [ENTRY_COUNT_BITS-1:0]   count;
  } answer_t;

  // Shadow copy of the table and the matrix shape
  logic [KEY_BITS-1:0]   entry_keys   [CAPACITY];
  logic [VALUE_BITS-1:0] entry_values [CAPACITY];
  int                    entry_total;
  logic [SHAPE_BITS-1:0] row_limit;
  logic [SHAPE_BITS-1:0] col_limit;

  answer_t answers [$];
  int      errors = 0;

  assign mismatch_count = errors;

  // Apply one command to the shadow table and return its answer.
  function automatic answer_t apply_command(cmd_t op, logic [INDEX_BITS-1:0] row,
                                            logic [INDEX_BITS-1:0] col,
                                            logic [VALUE_BITS-1:0] wval);
    answer_t             ans;
    logic [KEY_BITS-1:0] key;
    int                  lo;
    int                  hi;
    int                  mid;
    int                  k;
    bit                  hit;
    ans.status = ST_OK;
    ans.value  = '0;
    if ({1'b0, row} >= row_limit || {1'b0, col} >= col_limit) begin
      ans.status = ST_RANGE;
    end else begin
      key = {row, col};
      lo  = 0;
      hi  = entry_total;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (entry_keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      hit = (lo < entry_total) && (entry_keys[lo] == key);
      if (op == CMD_STORE) begin
        if (hit) begin
          entry_values[lo] = wval;
        end else if (entry_total >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (k = entry_total; k > lo; k--) begin
            entry_keys[k]   = entry_keys[k-1];
            entry_values[k] = entry_values[k-1];
          end
          entry_keys[lo]   = key;
          entry_values[lo] = wval;
          entry_total++;
        end
      end else if (hit) begin
        ans.value = entry_values[lo];
      end else begin
        ans.status = ST_NOTFOUND;
      end
    end
    ans.count = entry_total[ENTRY_COUNT_BITS-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      entry_total = 0;
      row_limit   = '0;
      col_limit   = '0;
      answers.delete();
    end else begin
      // Compare the result first; a new item may be taken on the same edge.
      if (out_valid) begin
        if (answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d value %h count %0d",
                     out_status, out_read_value, out_entry_count);
        end else begin
          want = answers.pop_front();
          if (out_status !== want.status || out_read_value !== want.value ||
              out_entry_count !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status %0d/%0d value %h/%h count %0d/%0d (expected/actual)",
                       want.status, out_status, want.value, out_read_value,
                       want.count, out_entry_count);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_ROWS) row_limit = cfg_data;
        else col_limit = cfg_data;
      end
      if (start && !busy)
        answers.push_back(apply_command(cmd_t'(in_cmd), in_row_index, in_col_index,
                                        in_write_value));
    end
    outstanding <= answers.size();
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  import stt_pkg::*;

  // Cycles with nothing moving on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last result, about one worst-case item.
  localparam int END_DRAIN      = 160;
  localparam int FULL_SPAN      = 65536;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          start           = 1'b0;
  logic                          in_cmd          = 1'b0;
  logic [INDEX_BITS-1:0]         in_row_index    = '0;
  logic [INDEX_BITS-1:0]         in_col_index    = '0;
  logic [VALUE_BITS-1:0]         in_write_value  = '0;
  logic                          cfg_we          = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index       = '0;
  logic [SHAPE_BITS-1:0]         cfg_data        = '0;
  logic                          busy;
  logic                          out_valid;
  logic [STATUS_BITS-1:0]        out_status;
  logic [VALUE_BITS-1:0]         out_read_value;
  logic [ENTRY_COUNT_BITS-1:0]   out_entry_count;
  int                            mismatch_count;
  int                            outstanding;

  // Stimulus state: current shape, sender idle rate and positions stored so far
  int                    row_span;
  int                    col_span;
  int                    gap_pct;
  logic [KEY_BITS-1:0]   known_positions [$];
  int                    idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_triplet_table_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  triplet_table_checker table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  // Watchdog: reset the count on any item taken or result seen, bail out when stuck.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drop start and hold until every result is in and the block is idle.
  // Outstanding is registered, so the wait only errs on the long side.
  task automatic drain_table();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // Write both shape registers on back-to-back edges; call only while idle.
  task automatic set_shape(int rows, int cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_ROWS;
    cfg_data  <= rows[SHAPE_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_NUM_COLS;
    cfg_data  <= cols[SHAPE_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_span = rows;
    col_span = cols;
  endtask

  // Present one item and hold it until taken. Start stays high afterwards
  // unless a sender gap is drawn, so back-to-back items never toggle it.
  task automatic command(cmd_t op, logic [INDEX_BITS-1:0] row,
                         logic [INDEX_BITS-1:0] col, logic [VALUE_BITS-1:0] wval);
    in_cmd         <= op;
    in_row_index   <= row;
    in_col_index   <= col;
    in_write_value <= wval;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == CMD_STORE) known_positions.push_back({row, col});
    // Sender gaps land anywhere in the search, shift or reply.
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk);
    end
  endtask

  // One random item: mostly in-range positions, the non-fresh ones revisiting
  // stored ones so retrieves hit and stores overwrite; a few out of range.
  task automatic random_command(int store_pct, int fresh_pct);
    cmd_t                    op;
    int                      pick;
    logic [INDEX_BITS-1:0]   row;
    logic [INDEX_BITS-1:0]   col;
    logic [VALUE_BITS-1:0]   wval;
    logic [KEY_BITS-1:0]     key;
    op   = ($urandom_range(99) < store_pct) ? CMD_STORE : CMD_RETRIEVE;
    pick = $urandom_range(99);
    if (pick < 8 && (row_span < FULL_SPAN || col_span < FULL_SPAN)) begin
      row = INDEX_BITS'($urandom);
      col = INDEX_BITS'($urandom);
      if (row_span < FULL_SPAN && (col_span == FULL_SPAN || $urandom_range(1) == 1))
        row = INDEX_BITS'($urandom_range(FULL_SPAN - 1, row_span));
      else
        col = INDEX_BITS'($urandom_range(FULL_SPAN - 1, col_span));
    end else if (pick < 8 + fresh_pct || known_positions.size() == 0) begin
      row = INDEX_BITS'($urandom_range(row_span - 1, 0));
      col = INDEX_BITS'($urandom_range(col_span - 1, 0));
    end else begin
      key = known_positions[$urandom_range(known_positions.size() - 1, 0)];
      row = key[KEY_BITS-1:INDEX_BITS];
      col = key[INDEX_BITS-1:0];
    end
    pick = $urandom_range(99);
    if (pick < 10) wval = '0;
    else if (pick < 20) wval = '1;
    else wval = $urandom;
    command(op, row, col, wval);
  endtask

  initial begin
    row_span = 0;
    col_span = 0;
    gap_pct  = 30;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty shape after reset: everything is out of range.
    command(CMD_STORE,    16'h0000, 16'h0000, 32'h1234_5678);
    command(CMD_RETRIEVE, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    drain_table();
    // One row but no columns is still an empty shape.
    set_shape(1, 0);
    command(CMD_STORE,    16'h0000, 16'h0000, 32'h0000_0001);
    drain_table();

    // Widest shape: corners, row-major ordering, zero store, overwrite.
    set_shape(FULL_SPAN, FULL_SPAN);
    command(CMD_RETRIEVE, 16'h0000, 16'h0000, 32'hDEAD_BEEF);
    command(CMD_STORE,    16'h0000, 16'h0000, 32'hFFFF_FFFF);
    command(CMD_STORE,    16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5);
    command(CMD_STORE,    16'h0000, 16'hFFFF, 32'h0000_0000);
    command(CMD_STORE,    16'h0001, 16'h0000, 32'h5A5A_5A5A);
    command(CMD_STORE,    16'hFFFF, 16'h0000, 32'h0000_0001);
    command(CMD_STORE,    16'h0000, 16'h0001, 32'h8000_0000);
    command(CMD_RETRIEVE, 16'h0000, 16'hFFFF, 32'h0000_0000);
    command(CMD_RETRIEVE, 16'h0001, 16'h0000, 32'h0000_0000);
    command(CMD_RETRIEVE, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    command(CMD_STORE,    16'h0000, 16'h0000, 32'h0000_0000);
    command(CMD_RETRIEVE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    command(CMD_RETRIEVE, 16'h8000, 16'h7FFF, 32'h0000_0000);
    drain_table();

    // Indices exactly at the shape bound are rejected, one below is taken.
    set_shape(FULL_SPAN - 1, 16);
    command(CMD_STORE,    16'hFFFF, 16'h0000, 32'h0F0F_0F0F);
    command(CMD_STORE,    16'hFFFE, 16'h0010, 32'hF0F0_F0F0);
    command(CMD_STORE,    16'hFFFE, 16'h000F, 32'h3C3C_3C3C);
    command(CMD_RETRIEVE, 16'h0000, 16'h0001, 32'h0000_0000);
    drain_table();

    // Small shape with the sender idling 30%: heavy overwrite and hit traffic.
    set_shape(8, 8);
    repeat (170) random_command(60, 50);
    drain_table();

    // Full shape, sender idling 59%: mostly new stores, which fill the table.
    gap_pct = 59;
    set_shape(FULL_SPAN, FULL_SPAN);
    repeat (170) random_command(75, 70);
    drain_table();

    // Narrow rows, full columns, no idling: full-table rejections and
    // overwrites, with many stored positions now out of range.
    gap_pct = 0;
    set_shape(200, FULL_SPAN);
    repeat (160) random_command(50, 30);
    drain_table();

    repeat (END_DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
